/* sv/wawg_pkg.sv */
`timescale 1ns / 1ps

package wawg_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IG_W      = 24;
  localparam logic [IG_W-1:0] IG_RESET = 24'd65536;  // 1.0 in Q8.16

  // Rounded quotient magnitude width and quotient bits per divider stage
  localparam int unsigned DIV_W     = 104;
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_NS    = DIV_W / DIV_BITS;

  // Front arithmetic stages, two chained dividers, sign stage
  localparam int unsigned FRONT_LAT = 8;
  localparam int unsigned SIDE_LAT  = FRONT_LAT + 2 * DIV_NS + 1;

  localparam int unsigned TERM_W    = DIV_W + 1;
  localparam int unsigned DIFF_W    = TERM_W + 1;

endpackage

/* sv/wawg_in_if.sv */
`timescale 1ns / 1ps

interface wawg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] plus_weight;
  logic signed [31:0] minus_weight;
  logic signed [31:0] plus_sum;
  logic signed [31:0] minus_sum;
  logic signed [31:0] plus_weighted_sum;
  logic signed [31:0] minus_weighted_sum;

  modport source (
    output valid, coord_x, plus_weight, minus_weight, plus_sum, minus_sum,
           plus_weighted_sum, minus_weighted_sum,
    input  ready
  );
  modport sink (
    input  valid, coord_x, plus_weight, minus_weight, plus_sum, minus_sum,
           plus_weighted_sum, minus_weighted_sum,
    output ready
  );
endinterface

/* sv/wawg_out_if.sv */
`timescale 1ns / 1ps

interface wawg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gradient;
  logic               zero_divisor;
  logic               saturated;

  modport source (output valid, gradient, zero_divisor, saturated, input ready);
  modport sink (input valid, gradient, zero_divisor, saturated, output ready);
endinterface

/* sv/wawg_cfg_if.sv */
`timescale 1ns / 1ps

interface wawg_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] inverse_gamma;

  modport source (output valid, inverse_gamma, input ready);
  modport sink (input valid, inverse_gamma, output ready);
endinterface

/* sv/wa_wirelength_gradient.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    coord_x, plus/minus_weight, plus/minus_sum,
//                              plus/minus_weighted_sum (signed Q16.16)
// out_ch   out  valid/ready    gradient (Q16.16), zero_divisor, saturated
// cfg_ch   in   valid/ready    inverse_gamma (unsigned Q8.16)
//
// One request per cycle unless out_ch stalls; stages: 8 arithmetic, two
// 26-stage dividers at 4 quotient bits each, a sign stage, output register.
// The divider chain by |b| sets the depth. Reset clears valid bits and loads
// inverse_gamma with 1.0. A stall on out_ch freezes the whole pipeline and
// drops in_ch.ready; nothing advances until the output request is taken.

module wa_wirelength_gradient (
  input  logic        clk,
  input  logic        rst_n,
  wawg_in_if.sink     in_ch,
  wawg_out_if.source  out_ch,
  wawg_cfg_if.sink    cfg_ch
);

  localparam int unsigned LAT = wawg_pkg::SIDE_LAT;

  logic                          en;
  logic [wawg_pkg::IG_W-1:0]     ig_r;
  logic                          vld_r [LAT];
  logic                          zd_r  [LAT];
  logic                          out_vld_r;
  logic signed [31:0]            grad_r;
  logic                          zdo_r, sat_r;

  // Advance when the output register is empty or being drained
  assign en           = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ig_r <= wawg_pkg::IG_RESET;
    end else if (cfg_ch.valid) begin
      ig_r <= cfg_ch.inverse_gamma;
    end
  end

  // Minus side reuses the plus datapath with x and c negated:
  // (1 - x*ig)*b + c*ig == (1 + (-x)*ig)*b - (-c)*ig
  logic signed [32:0] xp, xm, cp, cm;
  logic signed [wawg_pkg::TERM_W-1:0] term_p, term_m;

  assign xp = 33'(in_ch.coord_x);
  assign xm = -33'(in_ch.coord_x);
  assign cp = 33'(in_ch.plus_weighted_sum);
  assign cm = -33'(in_ch.minus_weighted_sum);

  wawg_side u_plus (
    .clk       (clk),
    .en        (en),
    .coord_x   (xp),
    .weight    (in_ch.plus_weight),
    .sum       (in_ch.plus_sum),
    .wsum      (cp),
    .ig        (ig_r),
    .term      (term_p)
  );

  wawg_side u_minus (
    .clk       (clk),
    .en        (en),
    .coord_x   (xm),
    .weight    (in_ch.minus_weight),
    .sum       (in_ch.minus_sum),
    .wsum      (cm),
    .ig        (ig_r),
    .term      (term_m)
  );

  // Valid and zero-divisor flags travel beside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zd_r[0] <= (in_ch.plus_sum == 32'sd0) || (in_ch.minus_sum == 32'sd0);
      for (int i = 1; i < LAT; i++) begin
        zd_r[i] <= zd_r[i-1];
      end
    end
  end

  // Difference and saturation to 32 bits
  logic signed [wawg_pkg::DIFF_W-1:0] diff;
  logic                               ovf;
  logic signed [31:0]                 grad_nxt;
  logic                               sat_nxt;

  assign diff = wawg_pkg::DIFF_W'(term_p) - wawg_pkg::DIFF_W'(term_m);
  assign ovf  = !((&diff[wawg_pkg::DIFF_W-1:31]) || !(|diff[wawg_pkg::DIFF_W-1:31]));

  always_comb begin
    if (zd_r[LAT-1]) begin
      grad_nxt = '0;
      sat_nxt  = 1'b0;
    end else if (ovf) begin
      grad_nxt = diff[wawg_pkg::DIFF_W-1] ? $signed(32'h8000_0000) : $signed(32'h7fff_ffff);
      sat_nxt  = 1'b1;
    end else begin
      grad_nxt = diff[31:0];
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grad_r <= grad_nxt;
      zdo_r  <= zd_r[LAT-1];
      sat_r  <= sat_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.gradient     = grad_r;
  assign out_ch.zero_divisor = zdo_r;
  assign out_ch.saturated    = sat_r;

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_divisor |-> out_ch.gradient == 32'sd0 && !out_ch.saturated)
    else $error("zero divisor result not cleared");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      out_ch.gradient == $signed(32'h7fff_ffff) || out_ch.gradient == $signed(32'h8000_0000))
    else $error("saturated result not at a bound");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

endmodule

/* sv/wawg_side.sv */
`timescale 1ns / 1ps

module wawg_side (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [32:0]                  coord_x,
  input  logic signed [31:0]                  weight,
  input  logic signed [31:0]                  sum,
  input  logic signed [32:0]                  wsum,
  input  logic [wawg_pkg::IG_W-1:0]           ig,
  output logic signed [wawg_pkg::TERM_W-1:0]  term
);

  localparam int unsigned DW = wawg_pkg::DIV_W;
  localparam int unsigned NS = wawg_pkg::DIV_NS;

  typedef struct packed {
    logic [31:0]   rem;
    logic [DW-1:0] dq;
  } div_res_t;

  // Restoring division, DIV_BITS quotient bits per call
  function automatic div_res_t div_step(input logic [31:0] rem_i,
                                        input logic [DW-1:0] dq_i,
                                        input logic [31:0] d_i);
    logic [32:0]   r;
    logic [DW-1:0] q;
    div_res_t      res;
    r = {1'b0, rem_i};
    q = dq_i;
    for (int i = 0; i < wawg_pkg::DIV_BITS; i++) begin
      r = {r[31:0], q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (r >= {1'b0, d_i}) begin
        r    = r - {1'b0, d_i};
        q[0] = 1'b1;
      end
    end
    res.rem = r[31:0];
    res.dq  = q;
    return res;
  endfunction

  // S1: narrow products, magnitudes
  logic signed [57:0]  xg_r, cg1_r;
  logic [62:0]         bb1_r;
  logic [31:0]         babs1_r, aabs1_r;
  logic                asgn1_r;
  logic signed [31:0]  b1_r;
  logic signed [63:0]  bsq;

  assign bsq = sum * sum;

  always_ff @(posedge clk) begin
    if (en) begin
      xg_r    <= coord_x * $signed({1'b0, ig});
      cg1_r   <= wsum * $signed({1'b0, ig});
      bb1_r   <= bsq[62:0];
      babs1_r <= sum[31] ? 32'(-sum) : 32'(sum);
      aabs1_r <= weight[31] ? 32'(-weight) : 32'(weight);
      asgn1_r <= weight[31];
      b1_r    <= sum;
    end
  end

  // S2: t = 1.0 + x*ig
  logic signed [57:0]  t_r, cg2_r;
  logic [62:0]         bb2_r;
  logic [31:0]         babs2_r, aabs2_r;
  logic                asgn2_r;
  logic signed [31:0]  b2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= xg_r + $signed(58'h1_0000_0000);
      cg2_r   <= cg1_r;
      bb2_r   <= bb1_r;
      babs2_r <= babs1_r;
      aabs2_r <= aabs1_r;
      asgn2_r <= asgn1_r;
      b2_r    <= b1_r;
    end
  end

  // S3: t*b split in two partial products
  logic signed [64:0]  tb0_r;
  logic signed [57:0]  tb1_r, cg3_r;
  logic [62:0]         bb3_r;
  logic [31:0]         babs3_r, aabs3_r;
  logic                asgn3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tb0_r   <= $signed({1'b0, t_r[31:0]}) * b2_r;
      tb1_r   <= $signed(t_r[57:32]) * b2_r;
      cg3_r   <= cg2_r;
      bb3_r   <= bb2_r;
      babs3_r <= babs2_r;
      aabs3_r <= aabs2_r;
      asgn3_r <= asgn2_r;
    end
  end

  // S4: inner = t*b - c*ig
  logic signed [90:0]  inner_r;
  logic [62:0]         bb4_r;
  logic [31:0]         babs4_r, aabs4_r;
  logic                asgn4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      inner_r <= (91'(tb1_r) <<< 32) + 91'(tb0_r) - (91'(cg3_r) <<< 16);
      bb4_r   <= bb3_r;
      babs4_r <= babs3_r;
      aabs4_r <= aabs3_r;
      asgn4_r <= asgn3_r;
    end
  end

  // S5: magnitude and sign of the numerator
  logic [89:0]         mag_r;
  logic                neg5_r;
  logic [62:0]         bb5_r;
  logic [31:0]         babs5_r, aabs5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= inner_r[90] ? 90'(-inner_r) : 90'(inner_r);
      neg5_r  <= asgn4_r ^ inner_r[90];
      bb5_r   <= bb4_r;
      babs5_r <= babs4_r;
      aabs5_r <= aabs4_r;
    end
  end

  // S6: |a| * |inner| in three partial products
  logic [61:0]         pp0_r, pp1_r, pp2_r;
  logic                neg6_r;
  logic [62:0]         bb6_r;
  logic [31:0]         babs6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r   <= aabs5_r * mag_r[29:0];
      pp1_r   <= aabs5_r * mag_r[59:30];
      pp2_r   <= aabs5_r * mag_r[89:60];
      neg6_r  <= neg5_r;
      bb6_r   <= bb5_r;
      babs6_r <= babs5_r;
    end
  end

  // S7: numerator magnitude
  logic [121:0]        nsum;
  logic [119:0]        n_r;
  logic                neg7_r;
  logic [62:0]         bb7_r;
  logic [31:0]         babs7_r;

  assign nsum = 122'(pp0_r) + (122'(pp1_r) << 30) + (122'(pp2_r) << 60);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r     <= nsum[119:0];
      neg7_r  <= neg6_r;
      bb7_r   <= bb6_r;
      babs7_r <= babs6_r;
    end
  end

  // S8: round by adding half the divisor, then drop the 2^17 factor
  logic [120:0]        mrnd;
  logic [DW-1:0]       dvd_r;
  logic                neg8_r;
  logic [31:0]         babs8_r;

  assign mrnd = {n_r, 1'b0} + (121'(bb7_r) << 16);

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r   <= mrnd[120:17];
      neg8_r  <= neg7_r;
      babs8_r <= babs7_r;
    end
  end

  // Two chained dividers by |b|: stages 0..NS-1, then NS..2NS-1
  logic [DW-1:0] dq_r  [2*NS];
  logic [31:0]   rm_r  [2*NS];
  logic [31:0]   dv_r  [2*NS];
  logic          ng_r  [2*NS];

  for (genvar k = 0; k < 2 * NS; k++) begin : g_div
    logic [DW-1:0] dq_in;
    logic [31:0]   rm_in, dv_in;
    logic          ng_in;
    div_res_t      res;

    if (k == 0) begin : g_first
      assign dq_in = dvd_r;
      assign rm_in = '0;
      assign dv_in = babs8_r;
      assign ng_in = neg8_r;
    end else begin : g_next
      assign dq_in = dq_r[k-1];
      assign rm_in = (k == NS) ? 32'd0 : rm_r[k-1];
      assign dv_in = dv_r[k-1];
      assign ng_in = ng_r[k-1];
    end

    assign res = div_step(rm_in, dq_in, dv_in);

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[k] <= res.dq;
        rm_r[k] <= res.rem;
        dv_r[k] <= dv_in;
        ng_r[k] <= ng_in;
      end
    end
  end

  // Apply sign
  logic signed [wawg_pkg::TERM_W-1:0] term_r;
  logic signed [wawg_pkg::TERM_W-1:0] qs;

  assign qs = $signed({1'b0, dq_r[2*NS-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= ng_r[2*NS-1] ? -qs : qs;
    end
  end

  assign term = term_r;

endmodule

/* tb/wa_wirelength_gradient_checker.sv */
`timescale 1ns / 1ps

module wa_wirelength_gradient_checker (
  input  logic     clk,
  input  logic     rst_n,
  wawg_in_if       in_ch,
  wawg_out_if      out_ch,
  wawg_cfg_if      cfg_ch,
  output int       mismatch_count,
  output int       gradients_pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [31:0] gradient;
    logic        zero_divisor;
    logic        saturated;
  } gradient_t;

  gradient_t                   expected_gradients[$];
  logic [wawg_pkg::IG_W-1:0]   cur_ig;

  // one side of the gradient, rounded to Q16.16, ties away from zero
  function automatic wide_t side_gradient(wide_t x, wide_t a, wide_t b, wide_t c,
                                          wide_t g, bit plus);
    wide_t xg, t, cg, tb, inner, num, den, mag, q, r;
    xg    = x * g;
    t     = (wide_t'(1) <<< 32) + (plus ? xg : -xg);
    cg    = c * g * 65536;
    tb    = t * b;
    inner = plus ? tb - cg : tb + cg;
    num   = a * inner;
    den   = b * b * 65536;
    mag   = (num < 0) ? -num : num;
    q     = mag / den;
    r     = mag % den;
    if (2 * r >= den) q = q + 1;
    return (num < 0) ? -q : q;
  endfunction

  function automatic gradient_t predict_gradient(logic [wawg_pkg::IG_W-1:0] ig);
    gradient_t g;
    wide_t     diff, gw;
    g  = '0;
    gw = wide_t'({1'b0, ig});
    if (in_ch.plus_sum == 0 || in_ch.minus_sum == 0) begin
      g.zero_divisor = 1'b1;
      return g;
    end
    diff = side_gradient(wide_t'(in_ch.coord_x), wide_t'(in_ch.plus_weight),
                         wide_t'(in_ch.plus_sum), wide_t'(in_ch.plus_weighted_sum),
                         gw, 1'b1)
         - side_gradient(wide_t'(in_ch.coord_x), wide_t'(in_ch.minus_weight),
                         wide_t'(in_ch.minus_sum), wide_t'(in_ch.minus_weighted_sum),
                         gw, 1'b0);
    if (diff > 64'sh7FFFFFFF) begin
      g.gradient  = 32'h7FFFFFFF;
      g.saturated = 1'b1;
    end else if (diff < -64'sh80000000) begin
      g.gradient  = 32'h80000000;
      g.saturated = 1'b1;
    end else begin
      g.gradient = diff[31:0];
    end
    return g;
  endfunction

  assign gradients_pending = expected_gradients.size();

  always @(posedge clk) begin
    gradient_t exp_g;
    if (!rst_n) begin
      cur_ig         <= wawg_pkg::IG_RESET;
      mismatch_count <= 0;
      expected_gradients.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) cur_ig <= cfg_ch.inverse_gamma;
      if (in_ch.valid && in_ch.ready) expected_gradients.push_back(predict_gradient(cur_ig));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_gradients.size() == 0) begin
          $display("%0t: unexpected result grad=%h zd=%b sat=%b", $time,
                   out_ch.gradient, out_ch.zero_divisor, out_ch.saturated);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_g = expected_gradients.pop_front();
          if (exp_g.gradient !== out_ch.gradient || exp_g.zero_divisor !== out_ch.zero_divisor
              || exp_g.saturated !== out_ch.saturated) begin
            $display("%0t: expected grad=%h zd=%b sat=%b, actual grad=%h zd=%b sat=%b",
                     $time, exp_g.gradient, exp_g.zero_divisor, exp_g.saturated,
                     out_ch.gradient, out_ch.zero_divisor, out_ch.saturated);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/wa_wirelength_gradient_tb.sv */
`timescale 1ns / 1ps

module wa_wirelength_gradient_tb;

  localparam int DRAIN_CYCLES = 70;        // margin beyond the pipeline depth
  localparam int CYCLE_LIMIT  = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatch_count;
  int   gradients_pending;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  wawg_in_if  in_ch ();
  wawg_out_if out_ch ();
  wawg_cfg_if cfg_ch ();

  wa_wirelength_gradient uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  wa_wirelength_gradient_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_ch            (cfg_ch),
    .mismatch_count    (mismatch_count),
    .gradients_pending (gradients_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the pipeline hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: drop ready on a random share of cycles
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Pick a field value: mostly moderate, some full-range, some corner values
  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(5))
        0: return 32'h00000000;
        1: return 32'h00000001;
        2: return 32'hFFFFFFFF;
        3: return 32'h7FFFFFFF;
        4: return 32'h80000000;
        default: return 32'h00010000;
      endcase
    end
    if (sel < 40) return $urandom;
    return 32'(signed'($urandom_range(0, 32'h7FFFFF)) - 32'sh400000);
  endfunction

  // Present one request and hold it until accepted, then maybe idle
  task automatic send_pin(logic [31:0] x, logic [31:0] ap, logic [31:0] am,
                          logic [31:0] bp, logic [31:0] bm,
                          logic [31:0] cp, logic [31:0] cm);
    in_ch.valid              <= 1'b1;
    in_ch.coord_x            <= x;
    in_ch.plus_weight        <= ap;
    in_ch.minus_weight       <= am;
    in_ch.plus_sum           <= bp;
    in_ch.minus_sum          <= bm;
    in_ch.plus_weighted_sum  <= cp;
    in_ch.minus_weighted_sum <= cm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_random_pin();
    send_pin(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
             pick_word(), pick_word());
  endtask

  // Drain the pipeline, then write inverse_gamma while idle
  task automatic write_gamma(logic [wawg_pkg::IG_W-1:0] ig);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (gradients_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.inverse_gamma <= ig;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) send_random_pin();
  endtask

  initial begin
    in_ch.valid              = 1'b0;
    in_ch.coord_x            = '0;
    in_ch.plus_weight        = '0;
    in_ch.minus_weight       = '0;
    in_ch.plus_sum           = '0;
    in_ch.minus_sum          = '0;
    in_ch.plus_weighted_sum  = '0;
    in_ch.minus_weighted_sum = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.inverse_gamma     = '0;
    out_ch.ready             = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases at the reset value of inverse_gamma (1.0)
    send_idle_pct = 30;
    recv_idle_pct = 63;
    send_pin(0, 0, 0, 0, 0, 0, 0);                                         // both divisors zero
    send_pin(32'h10000, 32'h10000, 32'h10000, 0, 32'h10000, 0, 0);         // plus divisor zero
    send_pin(32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);         // minus divisor zero
    send_pin(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0); // unit terms
    send_pin(32'h20000, 32'h8000, 32'h18000, 32'h30000, 32'h50000,
             32'h40000, 32'hFFFF0000);
    send_pin(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h7FFFFFFF);
    send_pin(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000);
    send_pin(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1, 0, 0);  // clamp high
    send_pin(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h1, 0, 0);  // clamp low
    send_pin(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h1,
             32'hFFFFFFFF, 32'h1);
    send_pin(32'h1, 32'h1, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF);
    send_pin(32'h00018000, 32'h00008000, 32'h00008000, 32'h00020000, 32'h00020000,
             32'h00030000, 32'h00030000);                                  // exact sides, zero gradient
    send_pin(32'hFFFE8000, 32'hFFFF8000, 32'h00008000, 32'hFFFE0000, 32'h00020000,
             32'hFFFD0000, 32'h00030000);
    send_pin(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h80000000);
    send_pin(32'h12345678, 32'h0, 32'h0, 32'h00010000, 32'hFFFF0000, 32'h5, 32'h5);

    // Sweep inverse_gamma through its extremes and a random value
    write_gamma('0);
    random_phase(210, 30, 63);
    write_gamma({wawg_pkg::IG_W{1'b1}});
    random_phase(210, 63, 30);
    write_gamma(wawg_pkg::IG_W'($urandom));
    random_phase(230, 0, 0);

    // Drain and deliver the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (gradients_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
